// File: src/gf64_pkg.sv
// Package for the GF(2^64) multiplier: widths, cell sizing and the cell payload type.
// Used by the interfaces, the multiply/fold cell and the top level. No dependencies.
`default_nettype none

package gf64_pkg;

   localparam int DataWidth = 64;
   localparam int PolyWidth = 32;
   localparam int AccWidth  = 2 * DataWidth;
   localparam int CellBits  = 8;

   localparam logic [PolyWidth-1:0] PolyReset = PolyWidth'(27);

   typedef struct packed {
      logic [DataWidth-1:0] src;
      logic [DataWidth-1:0] coef;
      logic [AccWidth-1:0]  acc;
   } cell_data_type;

endpackage

`default_nettype wire

// File: src/gf64_if.sv
// Handshake interfaces for the request, response and register write channels.
// Depends on gf64_pkg for the field widths.
`default_nettype none

interface gf64_req_if import gf64_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [DataWidth-1:0] multiplicand_a;
   logic [DataWidth-1:0] multiplicand_b;

   modport source (output valid, output multiplicand_a, output multiplicand_b, input ready);
   modport sink (input valid, input multiplicand_a, input multiplicand_b, output ready);
endinterface

interface gf64_rsp_if import gf64_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [DataWidth-1:0] field_product;

   modport source (output valid, output field_product, input ready);
   modport sink (input valid, input field_product, output ready);
endinterface

interface gf64_csr_if import gf64_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [PolyWidth-1:0] reduction_poly_low;

   modport source (output valid, output reduction_poly_low, input ready);
   modport sink (input valid, input reduction_poly_low, output ready);
endinterface

`default_nettype wire

// File: src/gf64_cell.sv
// One cell of the multiply/fold chain: XORs a few shifted copies of src into the accumulator.
// Depends on gf64_pkg for the payload type and widths.
`default_nettype none

module gf64_cell import gf64_pkg::*; #(
   parameter int CELL_BITS = CellBits,
   parameter int BASE      = 0
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          in_valid,
   output logic               in_ready,
   input  wire cell_data_type in_data,
   output logic               out_valid,
   input  wire logic          out_ready,
   output cell_data_type      out_data
);

   logic          valid_ff;
   logic          valid_in;
   cell_data_type data_ff;
   cell_data_type data_in;
   logic [AccWidth-1:0] src_wide;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;
   assign src_wide  = {{(AccWidth-DataWidth){1'b0}}, in_data.src};

   always_comb begin
      data_in = in_data;
      for (int j = 0; j < CELL_BITS; j++) begin
         if (in_data.coef[BASE+j]) begin
            data_in.acc = data_in.acc ^ (src_wide << (BASE + j));
         end
      end
   end

   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

endmodule

`default_nettype wire

// File: src/gf2_64_multiplier_top.sv
// Top level of the GF(2^64) multiplier: reduction polynomial register and the cell chain.
// Depends on gf64_pkg, the gf64 interfaces and gf64_cell.
//
// Usage: each req transaction carries two field elements; each rsp transaction returns
// their product reduced modulo x^64 + P(x), in the order the requests were taken.
// P(x) is the low polynomial in the 32-bit register written over the csr channel,
// which is always ready; write it only while no product is outstanding.
// The datapath is a chain of cells, each handling CELL_BITS bits: 64/CELL_BITS cells
// form the carry-less product one byte of multiplicand_b at a time, then two groups of
// 32/CELL_BITS cells perform the two folds, one byte of the polynomial each.
// Each cell registers its transaction. Throughput is one transaction per cycle while
// rsp_bus.ready stays high. Each cell holds one transaction and moves it
// on as soon as its neighbor is free, so a stalled receiver first fills empty cells
// and req_bus.ready falls only once the whole chain is full.
// Reset empties the chain and restores the polynomial to x^4+x^3+x+1.
`default_nettype none

module gf2_64_multiplier_top import gf64_pkg::*; #(
   parameter int CELL_BITS = CellBits
) (
   input wire logic clock,
   input wire logic reset,
   gf64_req_if.sink   req_bus,
   gf64_rsp_if.source rsp_bus,
   gf64_csr_if.sink   csr_bus
);

   localparam int MulCells  = DataWidth / CELL_BITS;
   localparam int FoldCells = PolyWidth / CELL_BITS;
   localparam int NumCells  = MulCells + 2 * FoldCells;

   logic [PolyWidth-1:0] poly_ff;
   logic [PolyWidth-1:0] poly_in;

   logic          stage_valid [NumCells+1];
   logic          stage_ready [NumCells+1];
   cell_data_type stage_data  [NumCells+1];

   assign csr_bus.ready = 1'b1;
   assign poly_in = (csr_bus.valid) ? csr_bus.reduction_poly_low : poly_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         poly_ff <= PolyReset;
      end else begin
         poly_ff <= poly_in;
      end
   end

   assign stage_valid[0]     = req_bus.valid;
   assign req_bus.ready      = stage_ready[0];
   assign stage_data[0].src  = req_bus.multiplicand_a;
   assign stage_data[0].coef = req_bus.multiplicand_b;
   assign stage_data[0].acc  = '0;

   for (genvar c = 0; c < NumCells; c++) begin : g_cell
      localparam int Base = (c < MulCells) ? c * CELL_BITS
                                           : ((c - MulCells) % FoldCells) * CELL_BITS;
      cell_data_type cell_in;

      if (c >= MulCells && ((c - MulCells) % FoldCells) == 0) begin : g_fold_entry
         assign cell_in.src  = stage_data[c].acc[AccWidth-1:DataWidth];
         assign cell_in.coef = {{(DataWidth-PolyWidth){1'b0}}, poly_ff};
         assign cell_in.acc  = {{(AccWidth-DataWidth){1'b0}},
                                stage_data[c].acc[DataWidth-1:0]};
      end else begin : g_pass
         assign cell_in = stage_data[c];
      end

      gf64_cell #(
         .CELL_BITS (CELL_BITS),
         .BASE      (Base)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stage_valid[c]),
         .in_ready  (stage_ready[c]),
         .in_data   (cell_in),
         .out_valid (stage_valid[c+1]),
         .out_ready (stage_ready[c+1]),
         .out_data  (stage_data[c+1])
      );
   end

   assign rsp_bus.valid         = stage_valid[NumCells];
   assign stage_ready[NumCells] = rsp_bus.ready;
   assign rsp_bus.field_product = stage_data[NumCells].acc[DataWidth-1:0];

endmodule

`default_nettype wire
